/* design/idct8_pkg.sv */
package idct8_pkg;

  // input saturation range, signed bits
  localparam int COEF_WIDTH = 12;

  localparam int IN_W    = 12;  // coef port width
  localparam int SMP_W   = 15;  // sample port width
  localparam int ROW_W   = 17;  // row pass store width
  localparam int MUL_A_W = 18;  // multiplier data operand
  localparam int MUL_K_W = 13;  // multiplier constant operand (positive)
  localparam int PROD_W  = MUL_A_W + MUL_K_W;
  localparam int ACC_W   = 34;  // butterfly sums
  localparam int DIV_W   = 40;  // 41 * difference, magnitude, divided one bit per cycle
  localparam int REM_W   = 6;

  localparam int ROW_SHIFT = 11;
  localparam int COL_SHIFT = 15;

  localparam logic signed [MUL_K_W-1:0] K1 = 13'sd4017;
  localparam logic signed [MUL_K_W-1:0] K2 = 13'sd3784;
  localparam logic signed [MUL_K_W-1:0] K3 = 13'sd3406;
  localparam logic signed [MUL_K_W-1:0] K4 = 13'sd2896;
  localparam logic signed [MUL_K_W-1:0] K5 = 13'sd2276;
  localparam logic signed [MUL_K_W-1:0] K6 = 13'sd1567;
  localparam logic signed [MUL_K_W-1:0] K7 = 13'sd799;

  localparam logic [REM_W:0]           HR_DIVISOR = 7'd58;

  localparam logic signed [ROW_W-1:0] SAT_HI = ROW_W'((1 << (COEF_WIDTH - 1)) - 1);
  localparam logic signed [ROW_W-1:0] SAT_LO = ROW_W'(-(1 << (COEF_WIDTH - 1)));

  typedef enum logic [6:0] {
    S_COLLECT = 7'b0000001,
    S_LOAD    = 7'b0000010,
    S_CALC    = 7'b0000100,
    S_DIV     = 7'b0001000,
    S_STORE   = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_e;

endpackage

/* design/idct_8x8_fixed_point_unit.sv */
// channel  dir  handshake                     payload
// coef     in   coef_valid_i / coef_ready_o    coef_i (12b signed)
// sample   out  sample_valid_o / sample_ready_i sample_o (15b signed), block_last_o
//
// coefficients are taken one per cycle while collecting and coef_valid_i is high, 64 for a block
// then 16 transform vectors (8 rows, 8 columns), each in order: load, calc
// through one shared multiplier, the bit-serial divide by 58, then store
// samples leave one at a time: single-port read of the row store, then registered
// reset clears control state only; the stores need no clearing
// a stalled sample holds in the output register while the next block is collected
module idct_8x8_fixed_point_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   coef_valid_i,
  output logic                                   coef_ready_o,
  input  logic signed [idct8_pkg::IN_W-1:0]      coef_i,
  output logic                                   sample_valid_o,
  input  logic                                   sample_ready_i,
  output logic signed [idct8_pkg::SMP_W-1:0]     sample_o,
  output logic                                   block_last_o
);

  localparam int XW = idct8_pkg::ROW_W;
  localparam int AW = idct8_pkg::ACC_W;
  localparam int NW = idct8_pkg::DIV_W;
  localparam int RW = idct8_pkg::REM_W;

  idct8_pkg::state_e state_q;
  logic [5:0] cnt_q;
  logic [2:0] vec_q;
  logic       col_q;

  logic [idct8_pkg::IN_W-1:0] coef_mem [64];
  logic [XW-1:0]              row_mem  [64];
  logic [idct8_pkg::IN_W-1:0] coef_rd_q;
  logic [XW-1:0]              row_rd_q;
  logic [5:0]                 rd_addr;
  logic [5:0]                 wr_addr;
  logic [XW-1:0]              wr_data;

  logic signed [XW-1:0] x_q [8];
  logic signed [AW-1:0] p_q;
  logic signed [AW-1:0] a4_q, a5_q, a6_q, a7_q;
  logic signed [AW-1:0] b0_q, b1_q, b2_q, b3_q, b4_q, b5_q, b6_q, b7_q;
  logic signed [AW-1:0] e0_q, e1_q, e2_q, e3_q, h5_q, h6_q;

  logic [NW-1:0] dv5_q, dv6_q;
  logic [RW-1:0] rem5_q, rem6_q;
  logic          neg5_q, neg6_q;

  logic signed [idct8_pkg::SMP_W-1:0] sample_q;
  logic                               valid_q;
  logic                               last_q;

  logic signed [XW-1:0]                      coef_ext;
  logic signed [XW-1:0]                      coef_sat;
  logic signed [idct8_pkg::MUL_A_W-1:0]      mul_a;
  logic signed [idct8_pkg::MUL_K_W-1:0]      mul_k;
  logic signed [idct8_pkg::PROD_W-1:0]       prod;
  logic signed [AW-1:0]                      prod_ext;
  logic [RW:0]                               r5, r6;
  logic                                      ge5, ge6;
  logic signed [AW-1:0]                      st_a, st_b, st_sum;
  logic                                      st_sub;
  logic                                      in_beat;
  logic [2:0]                                ld_idx;
  logic signed [NW-1:0]                      h5_ext, h6_ext;
  logic signed [NW-1:0]                      n5, n6;

  assign coef_ready_o   = (state_q == idct8_pkg::S_COLLECT);
  assign in_beat        = coef_valid_i && coef_ready_o;
  assign sample_valid_o = valid_q;
  assign sample_o       = sample_q;
  assign block_last_o   = last_q;

  // input saturation to the configured coefficient range
  always_comb begin
    coef_ext = {{(XW - idct8_pkg::IN_W){coef_i[idct8_pkg::IN_W-1]}}, coef_i};
    coef_sat = coef_ext;
    if (coef_ext > idct8_pkg::SAT_HI) coef_sat = idct8_pkg::SAT_HI;
    if (coef_ext < idct8_pkg::SAT_LO) coef_sat = idct8_pkg::SAT_LO;
  end

  // row pass walks rows, column pass walks columns (transposed addressing)
  always_comb begin
    if (state_q == idct8_pkg::S_LOAD) begin
      rd_addr = col_q ? {cnt_q[2:0], vec_q} : {vec_q, cnt_q[2:0]};
    end else begin
      rd_addr = cnt_q;
    end
    wr_addr = col_q ? {cnt_q[2:0], vec_q} : {vec_q, cnt_q[2:0]};
  end

  assign ld_idx = 3'(cnt_q - 6'd1);

  // shared multiplier operand select, one product per calc step
  always_comb begin
    mul_a = '0;
    mul_k = idct8_pkg::K1;
    case (cnt_q)
      6'd0:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[1]); mul_k = idct8_pkg::K7; end
      6'd1:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[7]); mul_k = idct8_pkg::K1; end
      6'd2:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[5]); mul_k = idct8_pkg::K3; end
      6'd3:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[3]); mul_k = idct8_pkg::K5; end
      6'd4:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[3]); mul_k = idct8_pkg::K3; end
      6'd5:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[5]); mul_k = idct8_pkg::K5; end
      6'd6:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[7]); mul_k = idct8_pkg::K7; end
      6'd7:  begin mul_a = idct8_pkg::MUL_A_W'(x_q[1]); mul_k = idct8_pkg::K1; end
      6'd9:  begin mul_a = b0_q[idct8_pkg::MUL_A_W-1:0]; mul_k = idct8_pkg::K4; end
      6'd10: begin mul_a = b1_q[idct8_pkg::MUL_A_W-1:0]; mul_k = idct8_pkg::K4; end
      6'd11: begin mul_a = idct8_pkg::MUL_A_W'(x_q[2]); mul_k = idct8_pkg::K6; end
      6'd12: begin mul_a = idct8_pkg::MUL_A_W'(x_q[6]); mul_k = idct8_pkg::K2; end
      6'd13: begin mul_a = idct8_pkg::MUL_A_W'(x_q[2]); mul_k = idct8_pkg::K2; end
      6'd14: begin mul_a = idct8_pkg::MUL_A_W'(x_q[6]); mul_k = idct8_pkg::K6; end
      default: begin mul_a = '0; mul_k = idct8_pkg::K1; end
    endcase
    prod     = mul_a * mul_k;
    prod_ext = {{(AW - idct8_pkg::PROD_W){prod[idct8_pkg::PROD_W-1]}}, prod};
  end

  // times 41 as 32 + 8 + 1
  assign h5_ext = {{(NW - AW){h5_q[AW-1]}}, h5_q};
  assign h6_ext = {{(NW - AW){h6_q[AW-1]}}, h6_q};
  assign n5     = (h5_ext <<< 5) + (h5_ext <<< 3) + h5_ext;
  assign n6     = (h6_ext <<< 5) + (h6_ext <<< 3) + h6_ext;

  // restoring divide by 58, one quotient bit per cycle
  always_comb begin
    r5  = {rem5_q, dv5_q[NW-1]};
    r6  = {rem6_q, dv6_q[NW-1]};
    ge5 = (r5 >= idct8_pkg::HR_DIVISOR);
    ge6 = (r6 >= idct8_pkg::HR_DIVISOR);
  end

  // output butterfly, one sample per store cycle
  always_comb begin
    st_a   = e0_q;
    st_b   = b7_q;
    st_sub = 1'b0;
    case (cnt_q[2:0])
      3'd0: begin st_a = e0_q; st_b = b7_q; st_sub = 1'b0; end
      3'd1: begin st_a = e1_q; st_b = h6_q; st_sub = 1'b0; end
      3'd2: begin st_a = e2_q; st_b = h5_q; st_sub = 1'b0; end
      3'd3: begin st_a = e3_q; st_b = b4_q; st_sub = 1'b0; end
      3'd4: begin st_a = e3_q; st_b = b4_q; st_sub = 1'b1; end
      3'd5: begin st_a = e2_q; st_b = h5_q; st_sub = 1'b1; end
      3'd6: begin st_a = e1_q; st_b = h6_q; st_sub = 1'b1; end
      default: begin st_a = e0_q; st_b = b7_q; st_sub = 1'b1; end
    endcase
    st_sum = st_sub ? (st_a - st_b) : (st_a + st_b);
    if (col_q) begin
      wr_data = {{(XW - idct8_pkg::SMP_W){st_sum[idct8_pkg::COL_SHIFT + idct8_pkg::SMP_W - 1]}},
                 st_sum[idct8_pkg::COL_SHIFT + idct8_pkg::SMP_W - 1:idct8_pkg::COL_SHIFT]};
    end else begin
      wr_data = st_sum[idct8_pkg::ROW_SHIFT + XW - 1:idct8_pkg::ROW_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      coef_mem[cnt_q] <= coef_sat[idct8_pkg::IN_W-1:0];
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == idct8_pkg::S_STORE) begin
      row_mem[wr_addr] <= wr_data;
    end
    row_rd_q <= row_mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == idct8_pkg::S_LOAD && cnt_q != 6'd0) begin
      x_q[ld_idx] <= col_q ? row_rd_q
                           : {{(XW - idct8_pkg::IN_W){coef_rd_q[idct8_pkg::IN_W-1]}}, coef_rd_q};
    end
    if (state_q == idct8_pkg::S_CALC) begin
      p_q <= prod_ext;
      case (cnt_q)
        6'd1:  a4_q <= p_q;
        6'd2:  a4_q <= a4_q - p_q;
        6'd3:  a5_q <= p_q;
        6'd4:  a5_q <= a5_q - p_q;
        6'd5:  a6_q <= p_q;
        6'd6:  a6_q <= a6_q + p_q;
        6'd7:  a7_q <= p_q;
        6'd8: begin
          a7_q <= a7_q + p_q;
          b0_q <= AW'(x_q[0]) + AW'(x_q[4]);
          b1_q <= AW'(x_q[0]) - AW'(x_q[4]);
        end
        6'd10: b0_q <= p_q;
        6'd11: b1_q <= p_q;
        6'd12: b2_q <= p_q;
        6'd13: b2_q <= b2_q - p_q;
        6'd14: b3_q <= p_q;
        6'd15: begin
          b3_q <= b3_q + p_q;
          b4_q <= a4_q + a5_q;
          b5_q <= a4_q - a5_q;
          b6_q <= a7_q - a6_q;
          b7_q <= a6_q + a7_q;
        end
        6'd16: begin
          e0_q <= b0_q + b3_q;
          e1_q <= b1_q + b2_q;
          e2_q <= b1_q - b2_q;
          e3_q <= b0_q - b3_q;
          h5_q <= b6_q - b5_q;
          h6_q <= b5_q + b6_q;
        end
        6'd17: begin
          dv5_q <= n5;
          dv6_q <= n6;
        end
        6'd18: begin
          // divide magnitudes, sign restored afterwards (truncation toward zero)
          neg5_q <= dv5_q[NW-1];
          neg6_q <= dv6_q[NW-1];
          dv5_q  <= dv5_q[NW-1] ? (~dv5_q + NW'(1)) : dv5_q;
          dv6_q  <= dv6_q[NW-1] ? (~dv6_q + NW'(1)) : dv6_q;
          rem5_q <= '0;
          rem6_q <= '0;
        end
        default: ;
      endcase
    end
    if (state_q == idct8_pkg::S_DIV) begin
      if (cnt_q == 6'(NW)) begin
        h5_q <= neg5_q ? -signed'(dv5_q[AW-1:0]) : signed'(dv5_q[AW-1:0]);
        h6_q <= neg6_q ? -signed'(dv6_q[AW-1:0]) : signed'(dv6_q[AW-1:0]);
      end else begin
        rem5_q <= ge5 ? RW'(r5 - idct8_pkg::HR_DIVISOR) : r5[RW-1:0];
        rem6_q <= ge6 ? RW'(r6 - idct8_pkg::HR_DIVISOR) : r6[RW-1:0];
        dv5_q  <= {dv5_q[NW-2:0], ge5};
        dv6_q  <= {dv6_q[NW-2:0], ge6};
      end
    end
    if (state_q == idct8_pkg::S_EMIT_WR) begin
      sample_q <= row_rd_q[idct8_pkg::SMP_W-1:0];
      last_q   <= (cnt_q == 6'd63);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idct8_pkg::S_COLLECT;
      cnt_q   <= '0;
      vec_q   <= '0;
      col_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (state_q == idct8_pkg::S_EMIT_WR) begin
        valid_q <= 1'b1;
      end else if (sample_ready_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        idct8_pkg::S_COLLECT: begin
          if (in_beat) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd63) begin
              state_q <= idct8_pkg::S_LOAD;
              cnt_q   <= '0;
              vec_q   <= '0;
              col_q   <= 1'b0;
            end
          end
        end
        idct8_pkg::S_LOAD: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd8) begin
            state_q <= idct8_pkg::S_CALC;
            cnt_q   <= '0;
          end
        end
        idct8_pkg::S_CALC: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd18) begin
            state_q <= idct8_pkg::S_DIV;
            cnt_q   <= '0;
          end
        end
        idct8_pkg::S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NW)) begin
            state_q <= idct8_pkg::S_STORE;
            cnt_q   <= '0;
          end
        end
        idct8_pkg::S_STORE: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd7) begin
            cnt_q <= '0;
            vec_q <= vec_q + 3'd1;
            if (vec_q != 3'd7) begin
              state_q <= idct8_pkg::S_LOAD;
            end else if (!col_q) begin
              col_q   <= 1'b1;
              state_q <= idct8_pkg::S_LOAD;
            end else begin
              state_q <= idct8_pkg::S_EMIT_RD;
            end
          end
        end
        idct8_pkg::S_EMIT_RD: begin
          // read only when the output register is free at this edge
          if (!valid_q || sample_ready_i) begin
            state_q <= idct8_pkg::S_EMIT_WR;
          end
        end
        idct8_pkg::S_EMIT_WR: begin
          cnt_q   <= cnt_q + 6'd1;
          state_q <= idct8_pkg::S_EMIT_RD;
          if (cnt_q == 6'd63) begin
            cnt_q   <= '0;
            state_q <= idct8_pkg::S_COLLECT;
          end
        end
        default: begin
          state_q <= idct8_pkg::S_COLLECT;
          cnt_q   <= '0;
        end
      endcase
    end
  end

  // output register is empty whenever a sample is loaded into it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idct8_pkg::S_EMIT_WR |-> !valid_q)
    else $error("sample register overwritten");

  // the 64th coefficient starts the row pass
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && cnt_q == 6'd63 |=> state_q == idct8_pkg::S_LOAD && !col_q && vec_q == 3'd0)
    else $error("transform did not start after full block");

  // after the last sample of a block leaves, no sample follows at once
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q && sample_ready_i |=> !valid_q)
    else $error("sample after block end");

  // divider remainders stay below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idct8_pkg::S_DIV |-> (rem5_q < 6'd58) && (rem6_q < 6'd58))
    else $error("divider remainder out of range");

endmodule

/* verif/idct_8x8_fixed_point_unit_test.sv */
`timescale 1ns / 1ps

module idct_8x8_fixed_point_unit_test;

  localparam int N_BLOCKS = 7;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic coef_valid_i = 1'b0;
  logic coef_ready_o;
  logic signed [idct8_pkg::IN_W-1:0] coef_i = '0;
  logic sample_valid_o;
  logic sample_ready_i = 1'b0;
  logic signed [idct8_pkg::SMP_W-1:0] sample_o;
  logic block_last_o;

  typedef struct packed {
    logic signed [idct8_pkg::SMP_W-1:0] sample;
    logic                               last;
  } pixel_t;

  logic signed [idct8_pkg::IN_W-1:0] coef_queue[$];
  pixel_t pixel_queue[$];
  logic signed [63:0] coef_buf[64];
  int coef_cnt = 0;
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_go = 1'b0;
  bit stall_used = 1'b0;
  bit calm = 1'b0;

  always #1 clk_i = ~clk_i;

  idct_8x8_fixed_point_unit uut (.*);

  function automatic logic signed [63:0] div_root(logic signed [63:0] x);
    logic signed [63:0] m;
    m = x * 41;
    // truncate toward zero
    return (m < 0) ? -((-m) / 58) : m / 58;
  endfunction

  task automatic idct_1d(input logic signed [63:0] v[8], output logic signed [63:0] o[8]);
    logic signed [63:0] a4, a5, a6, a7, b0, b1, b2, b3, b4, b5, b6, b7;
    logic signed [63:0] e0, e1, e2, e3, h5, h6;
    a4 = v[1] * idct8_pkg::K7 - v[7] * idct8_pkg::K1;
    a5 = v[5] * idct8_pkg::K3 - v[3] * idct8_pkg::K5;
    a6 = v[3] * idct8_pkg::K3 + v[5] * idct8_pkg::K5;
    a7 = v[7] * idct8_pkg::K7 + v[1] * idct8_pkg::K1;
    b0 = (v[0] + v[4]) * idct8_pkg::K4;
    b1 = (v[0] - v[4]) * idct8_pkg::K4;
    b2 = v[2] * idct8_pkg::K6 - v[6] * idct8_pkg::K2;
    b3 = v[2] * idct8_pkg::K2 + v[6] * idct8_pkg::K6;
    b4 = a4 + a5; b5 = a4 - a5; b6 = a7 - a6; b7 = a6 + a7;
    e0 = b0 + b3; e1 = b1 + b2; e2 = b1 - b2; e3 = b0 - b3;
    h5 = div_root(b6 - b5);
    h6 = div_root(b5 + b6);
    o[0] = e0 + b7; o[1] = e1 + h6; o[2] = e2 + h5; o[3] = e3 + b4;
    o[4] = e3 - b4; o[5] = e2 - h5; o[6] = e1 - h6; o[7] = e0 - b7;
  endtask

  task automatic predict_block();
    logic signed [63:0] v[8], o[8];
    logic signed [63:0] mid[64];
    logic signed [idct8_pkg::ROW_W-1:0] rw;
    pixel_t px[64];
    for (int r = 0; r < 8; r++) begin
      for (int k = 0; k < 8; k++) v[k] = coef_buf[r*8+k];
      idct_1d(v, o);
      for (int k = 0; k < 8; k++) begin
        rw = idct8_pkg::ROW_W'(o[k] >>> idct8_pkg::ROW_SHIFT);
        mid[r*8+k] = rw;
      end
    end
    for (int k = 0; k < 8; k++) begin
      for (int r = 0; r < 8; r++) v[r] = mid[r*8+k];
      idct_1d(v, o);
      for (int r = 0; r < 8; r++) begin
        px[r*8+k].sample = idct8_pkg::SMP_W'(o[r] >>> idct8_pkg::COL_SHIFT);
        px[r*8+k].last = (r*8+k == 63);
      end
    end
    for (int i = 0; i < 64; i++) pixel_queue.push_back(px[i]);
  endtask

  function automatic logic signed [idct8_pkg::IN_W-1:0] rand_coef(int blk, int pos);
    int sel;
    sel = $urandom_range(0, 99);
    if (blk == 1) return (pos % 2) ? 12'sh7ff : 12'sh800;  // full-scale checker
    if (blk == 2) return (pos == 0) ? 12'sh7ff : 12'sh000;  // dc only
    if (sel < 10) return $urandom_range(0, 1) ? 12'sh7ff : 12'sh800;
    if (sel < 55 && pos > 15) return '0;
    if (sel < 80) return idct8_pkg::IN_W'($urandom_range(0, 64) - 32);
    return idct8_pkg::IN_W'($urandom);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (coef_valid_i && coef_ready_o) begin
      coef_buf[coef_cnt] = coef_i;
      coef_cnt = coef_cnt + 1;
      if (coef_cnt == 64) begin
        predict_block();
        coef_cnt = 0;
      end
    end
    if (rst_ni && (!coef_valid_i || coef_ready_o)) begin
      if (coef_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        coef_valid_i <= 1'b1;
        coef_i <= coef_queue.pop_front();
      end else begin
        coef_valid_i <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk_i) begin
    if (stall_go && !stall_used) begin
      hold_off   <= 3000;
      stall_used <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (sample_valid_o && sample_ready_i) begin
      if (pixel_queue.size() == 0) begin
        $error("sample beat with nothing expected");
        errors++;
      end else begin
        exp_px = pixel_queue.pop_front();
        if (sample_o !== exp_px.sample) begin
          $error("sample expected %0d actual %0d", exp_px.sample, sample_o);
          errors++;
        end
        if (block_last_o !== exp_px.last) begin
          $error("block_last expected %0d actual %0d", exp_px.last, block_last_o);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      sample_ready_i <= 1'b0;
    end else begin
      sample_ready_i <= rst_ni && (calm || $urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < N_BLOCKS; b++)
      for (int p = 0; p < 64; p++) begin
        if (b == 0) coef_queue.push_back(idct8_pkg::IN_W'(p * 64 - 2048));  // ramp
        else coef_queue.push_back(rand_coef(b, p));
      end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // long receiver stall so the block fills and stops taking coefficients
    wait (pixel_queue.size() > 0);
    @(posedge clk_i);
    stall_go <= 1'b1;
    wait (coef_queue.size() < 4 * 64);
    calm <= 1'b1;
    wait (coef_queue.size() < 2 * 64);
    calm <= 1'b0;
    wait (coef_queue.size() == 0 && !coef_valid_i);
    wait (pixel_queue.size() == 0 && coef_cnt == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
